### rtl/rlfw_pkg.sv
// shared types, constants and helper functions for the link failsafe watchdog
package rlfw_pkg;

    localparam int NUM_CHAN   = 8;
    localparam int RAMP_CHANS = 3;
    localparam int IO_CHAN    = 8;
    localparam int RAMP_N     = (RAMP_CHANS < NUM_CHAN) ? RAMP_CHANS : NUM_CHAN;
    localparam int APPLY_N    = (IO_CHAN < NUM_CHAN) ? IO_CHAN : NUM_CHAN;

    localparam int CHAN_W  = 12;
    localparam int TIME_W  = 32;
    localparam int LIMIT_W = 16;
    localparam int MODE_W  = 3;
    localparam int CIDX_W  = 8;
    localparam int CDAT_W  = 16;

    localparam int IN_DATA_W  = 2 * TIME_W + IO_CHAN * CHAN_W;
    localparam int OUT_DATA_W = IO_CHAN * CHAN_W + TIME_W;
    localparam int OUT_USER_W = 2;

    localparam logic [MODE_W-1:0] MODE_TICK       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CONNECT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DISCONNECT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SYNC       = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FRAME      = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_STALE    = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_FAILSAFE = 8'd1;
    localparam logic [CIDX_W-1:0] CFG_CENTER   = 8'd2;
    localparam logic [CIDX_W-1:0] CFG_STEP     = 8'd3;

    localparam logic [LIMIT_W-1:0] STALE_RST    = 16'd150;
    localparam logic [LIMIT_W-1:0] FAILSAFE_RST = 16'd600;
    localparam logic [CHAN_W-1:0]  CENTER_RST   = 12'd1500;
    localparam logic [CHAN_W-1:0]  STEP_RST     = 12'd10;
    localparam logic [CHAN_W-1:0]  HELD_RST     = 12'd1500;

    typedef struct packed {
        logic [LIMIT_W-1:0] stale_limit;
        logic [LIMIT_W-1:0] failsafe_limit;
        logic [CHAN_W-1:0]  center;
        logic [CHAN_W-1:0]  ramp_step;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0]              mode;
        logic [TIME_W-1:0]              now_ms;
        logic [TIME_W-1:0]              tx_time_ms;
        logic [IO_CHAN-1:0][CHAN_W-1:0] chan;
    } event_t;

    typedef struct packed {
        logic [NUM_CHAN-1:0][CHAN_W-1:0] held;
        logic [TIME_W-1:0]               clock_offset;
        logic                            offset_valid;
        logic [TIME_W-1:0]               last_aligned;
        logic                            aligned_valid;
        logic                            link_up;
    } state_t;

    typedef struct packed {
        logic [IO_CHAN-1:0][CHAN_W-1:0] chan;
        logic [TIME_W-1:0]              age_ms;
        logic                           frame_applied;
        logic                           ramp_active;
    } result_t;

    // negative differences read as zero age
    function automatic logic [TIME_W-1:0] age_clamp(input logic [TIME_W-1:0] diff);
        return diff[TIME_W-1] ? '0 : diff;
    endfunction

    // one step toward the target, landing on it when within the step
    function automatic logic [CHAN_W-1:0] ramp_toward(input logic [CHAN_W-1:0] v,
                                                      input logic [CHAN_W-1:0] target,
                                                      input logic [CHAN_W-1:0] step);
        logic [CHAN_W-1:0] up_gap;
        logic [CHAN_W-1:0] down_gap;
        logic [CHAN_W-1:0] res;
        up_gap   = target - v;
        down_gap = v - target;
        res      = v;
        if (v < target)
        begin
            res = (up_gap <= step) ? target : v + step;
        end
        else if (v > target)
        begin
            res = (down_gap <= step) ? target : v - step;
        end
        return res;
    endfunction

endpackage

### rtl/rlfw_cfg_regs.sv
// configuration register file for the watchdog limits, center and ramp step
module rlfw_cfg_regs
    import rlfw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [CIDX_W-1:0] wr_index,
    input  logic [CDAT_W-1:0] wr_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_STALE:    cfg_next.stale_limit    = wr_data;
                CFG_FAILSAFE: cfg_next.failsafe_limit = wr_data;
                CFG_CENTER:   cfg_next.center         = wr_data[CHAN_W-1:0];
                CFG_STEP:     cfg_next.ramp_step      = wr_data[CHAN_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stale_limit    <= STALE_RST;
            cfg_reg.failsafe_limit <= FAILSAFE_RST;
            cfg_reg.center         <= CENTER_RST;
            cfg_reg.ramp_step      <= STEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/rlfw_event.sv
// per-event update: connect, disconnect, sync alignment, age, freshness check and ramp
module rlfw_event
    import rlfw_pkg::*;
(
    input  event_t  ev,
    input  state_t  st,
    input  cfg_t    cfg,
    output state_t  st_next,
    output result_t res
);

    logic [TIME_W-1:0] tick_age;
    logic [TIME_W-1:0] frame_aligned;
    logic [TIME_W-1:0] frame_age;

    assign tick_age      = age_clamp(ev.now_ms - st.last_aligned);
    assign frame_aligned = st.offset_valid ? (ev.tx_time_ms + st.clock_offset) : ev.now_ms;
    assign frame_age     = age_clamp(ev.now_ms - frame_aligned);

    always_comb
    begin
        st_next           = st;
        res.age_ms        = '0;
        res.frame_applied = 1'b0;
        res.ramp_active   = 1'b0;

        unique case (ev.mode)
            MODE_TICK:
            begin
                if (st.aligned_valid)
                begin
                    res.age_ms = tick_age;
                    if (st.link_up && (tick_age > {{(TIME_W-LIMIT_W){1'b0}}, cfg.failsafe_limit}))
                    begin
                        for (int r = 0; r < RAMP_N; r++)
                        begin
                            st_next.held[r] = ramp_toward(st.held[r], cfg.center, cfg.ramp_step);
                        end
                        res.ramp_active = 1'b1;
                    end
                end
            end
            MODE_CONNECT:
            begin
                st_next.link_up = 1'b1;
            end
            MODE_DISCONNECT:
            begin
                st_next.link_up       = 1'b0;
                st_next.offset_valid  = 1'b0;
                st_next.clock_offset  = '0;
                st_next.last_aligned  = '0;
                st_next.aligned_valid = 1'b0;
                for (int c = 0; c < NUM_CHAN; c++)
                begin
                    st_next.held[c] = cfg.center;
                end
            end
            MODE_SYNC:
            begin
                // aligned time collapses to now, so the age is zero
                st_next.clock_offset  = ev.now_ms - ev.tx_time_ms;
                st_next.offset_valid  = 1'b1;
                st_next.last_aligned  = ev.now_ms;
                st_next.aligned_valid = 1'b1;
            end
            MODE_FRAME:
            begin
                st_next.last_aligned  = frame_aligned;
                st_next.aligned_valid = 1'b1;
                res.age_ms            = frame_age;
                if (frame_age <= {{(TIME_W-LIMIT_W){1'b0}}, cfg.stale_limit})
                begin
                    for (int c = 0; c < APPLY_N; c++)
                    begin
                        st_next.held[c] = ev.chan[c];
                    end
                    res.frame_applied = 1'b1;
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase

        for (int c = 0; c < IO_CHAN; c++)
        begin
            if (c < NUM_CHAN)
            begin
                res.chan[c] = st_next.held[c];
            end
            else
            begin
                res.chan[c] = '0;
            end
        end
    end

endmodule

### rtl/rlfw_state.sv
// link and channel state registers, updated once per processed word
module rlfw_state
    import rlfw_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   upd_en,
    input  state_t st_in,
    output state_t st
);

    state_t st_reg;
    state_t st_next;

    assign st_next = upd_en ? st_in : st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                st_reg.held[c] <= HELD_RST;
            end
            st_reg.clock_offset  <= '0;
            st_reg.offset_valid  <= 1'b0;
            st_reg.last_aligned  <= '0;
            st_reg.aligned_valid <= 1'b0;
            st_reg.link_up       <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    assign st = st_reg;

endmodule

### rtl/rc_link_failsafe_watchdog.sv
// top level of the radio link failsafe watchdog with ramp toward center
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser mode, tdata now, tx time, 8 channels
//  m_*      out  m_tvalid/m_tready  tuser applied/ramp flags, tdata channels, age
//  cfg_*    in   cfg_valid/cfg_ready register index and data, always ready
//
// one word per cycle sustained while m_tready holds; a word waits in the input
// register, is processed against the state there and lands in the result register.
// state updates when the input register hands its word to the result register,
// so the following word sees it with no gap.
// reset restores channels to 1500 and the limits to their defaults.
// a stalled result holds the pipe; an empty input register still fills behind it.
module rc_link_failsafe_watchdog
    import rlfw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // now_ms, tx_time_ms, chan_in_0..chan_in_7
    input  logic [MODE_W-1:0]     s_tuser,   // mode

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // chan_out_0..chan_out_7, age_ms
    output logic [OUT_USER_W-1:0] m_tuser,   // frame_applied, ramp_active

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CIDX_W-1:0]     cfg_index,
    input  logic [CDAT_W-1:0]     cfg_data
);

    logic    in_valid_reg;
    logic    in_valid_next;
    event_t  in_ev_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;
    logic    advance;

    cfg_t    cfg;
    state_t  st;
    state_t  st_upd;
    result_t res;
    event_t  ev_in;

    assign cfg_ready = 1'b1;

    rlfw_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // unpack the incoming word
    always_comb
    begin
        ev_in.mode       = s_tuser;
        ev_in.now_ms     = s_tdata[TIME_W-1:0];
        ev_in.tx_time_ms = s_tdata[2*TIME_W-1:TIME_W];
        for (int c = 0; c < IO_CHAN; c++)
        begin
            ev_in.chan[c] = s_tdata[2*TIME_W + c*CHAN_W +: CHAN_W];
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = (s_tvalid && s_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_ev_reg <= ev_in;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    rlfw_event u_event (
        .ev      (in_ev_reg),
        .st      (st),
        .cfg     (cfg),
        .st_next (st_upd),
        .res     (res)
    );

    rlfw_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd_en (advance),
        .st_in  (st_upd),
        .st     (st)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_res_reg.ramp_active, out_res_reg.frame_applied};
    assign m_tdata  = {out_res_reg.age_ms, out_res_reg.chan};

endmodule

### rtl/rlfw_checker.sv
// port-level checks on the watchdog result stream, bound to the top level
module rlfw_checker
    import rlfw_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // a frame and a ramp never come from the same event
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("frame applied and ramp flagged together");

    // ramping needs an age past the failsafe limit, so never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[OUT_DATA_W-1:IO_CHAN*CHAN_W] != '0)
        else $error("ramp step with zero age");

    // an applied frame is within the 16-bit stale limit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[OUT_DATA_W-1:IO_CHAN*CHAN_W+LIMIT_W] == '0)
        else $error("applied frame older than any stale limit");

endmodule

bind rc_link_failsafe_watchdog rlfw_checker u_rlfw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
